>>> hdl/tia_pkg.sv
// ----------------------------------------------------------------------------
// tia_pkg
// Shared types and codes for the triangle index assembler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tia_pkg;

  localparam int unsigned IdxW    = 32;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned PhaseW  = 2;

  // primitive modes
  localparam logic [ModeW-1:0] MODE_LIST  = 2'd0;
  localparam logic [ModeW-1:0] MODE_STRIP = 2'd1;
  localparam logic [ModeW-1:0] MODE_FAN   = 2'd2;
  localparam logic [ModeW-1:0] MODE_OTHER = 2'd3;

  // end-of-primitive status codes
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_RANGE     = 3'd1;
  localparam logic [StatusW-1:0] ST_MODE      = 3'd2;
  localparam logic [StatusW-1:0] ST_LISTCOUNT = 3'd3;
  localparam logic [StatusW-1:0] ST_FEW       = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HAS_INDEX = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_VCOUNT    = 2'd2;

  // list phase values
  localparam logic [PhaseW-1:0] PHASE_FIRST  = 2'd0;
  localparam logic [PhaseW-1:0] PHASE_SECOND = 2'd1;
  localparam logic [PhaseW-1:0] PHASE_THIRD  = 2'd2;

  typedef struct packed {
    logic [ModeW-1:0] primitive_mode;
    logic             has_index_buffer;
    logic [IdxW-1:0]  vtx_limit;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0] index_value;
    logic            is_last;
  } item_t;

  typedef struct packed {
    logic [IdxW-1:0]    corner_a;
    logic [IdxW-1:0]    corner_b;
    logic [IdxW-1:0]    corner_c;
    logic               triangle_valid;
    logic               end_of_primitive;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/tia_cfg_regs.sv
// ----------------------------------------------------------------------------
// tia_cfg_regs
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tia_cfg_regs
  import tia_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_addr,
  input  wire logic [CfgW-1:0]    cfg_wdata,
  output cfg_t                    cfg
);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.primitive_mode   <= MODE_LIST;
      cfg.has_index_buffer <= 1'b1;
      cfg.vtx_limit        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MODE:      cfg.primitive_mode   <= cfg_wdata[ModeW-1:0];
        CFG_HAS_INDEX: cfg.has_index_buffer <= cfg_wdata[0];
        CFG_VCOUNT:    cfg.vtx_limit        <= cfg_wdata[IdxW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/tia_assemble.sv
// ----------------------------------------------------------------------------
// tia_assemble
// Primitive state and triangle assembly for one registered index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tia_assemble
  import tia_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire item_t item,
  input  wire logic  advance,
  output result_t    result,
  output logic       has_result
);

  logic [IdxW-1:0]   first_index;
  logic [IdxW-1:0]   older_index;
  logic [IdxW-1:0]   newer_index;
  logic [IdxW-1:0]   index_count;
  logic [PhaseW-1:0] list_phase;
  logic              range_error_seen;

  logic [IdxW-1:0]   first_index_next;
  logic [IdxW-1:0]   older_index_next;
  logic [IdxW-1:0]   newer_index_next;
  logic [IdxW-1:0]   index_count_next;
  logic [PhaseW-1:0] list_phase_next;
  logic              range_error_seen_next;

  logic [IdxW-1:0] cur;
  logic            tri_hit;
  logic            count_ge2;
  logic [IdxW-1:0] ca;
  logic [IdxW-1:0] cb;
  logic [StatusW-1:0] st;

  // current index and range check
  assign cur                   = cfg.has_index_buffer ? item.index_value : index_count;
  assign range_error_seen_next = range_error_seen | (cur >= cfg.vtx_limit);
  assign count_ge2             = (index_count >= IdxW'(2));

  // triangle selection per mode
  always_comb begin
    tri_hit = 1'b0;
    ca      = '0;
    cb      = '0;
    unique case (cfg.primitive_mode)
      MODE_LIST: begin
        if (list_phase == PHASE_THIRD) begin
          tri_hit = 1'b1;
          ca      = older_index;
          cb      = newer_index;
        end
      end
      MODE_STRIP: begin
        if (count_ge2) begin
          tri_hit = 1'b1;
          ca      = index_count[0] ? newer_index : older_index;
          cb      = index_count[0] ? older_index : newer_index;
        end
      end
      MODE_FAN: begin
        if (count_ge2) begin
          tri_hit = 1'b1;
          ca      = first_index;
          cb      = newer_index;
        end
      end
      MODE_OTHER: ;
      default: ;
    endcase
  end

  // history, phase and saturating count
  always_comb begin
    first_index_next = (index_count == '0) ? cur : first_index;
    older_index_next = older_index;
    newer_index_next = newer_index;
    if (cfg.primitive_mode == MODE_LIST) begin
      if (list_phase == PHASE_FIRST) older_index_next = cur;
      else if (list_phase == PHASE_SECOND) newer_index_next = cur;
    end else begin
      older_index_next = newer_index;
      newer_index_next = cur;
    end
    list_phase_next  = (list_phase >= PHASE_THIRD) ? PHASE_FIRST : list_phase + PhaseW'(1);
    index_count_next = (index_count == '1) ? index_count : index_count + IdxW'(1);
  end

  // status of the primitive, meaningful on the last index only
  always_comb begin
    st = ST_OK;
    if (item.is_last) begin
      if (range_error_seen_next) begin
        st = ST_RANGE;
      end else if (cfg.primitive_mode == MODE_LIST) begin
        if (list_phase_next != PHASE_FIRST) st = ST_LISTCOUNT;
      end else if (cfg.primitive_mode == MODE_OTHER) begin
        st = ST_MODE;
      end else if (index_count_next < IdxW'(3)) begin
        st = ST_FEW;
      end
    end
  end

  // result item
  always_comb begin
    result.corner_a         = tri_hit ? ca : '0;
    result.corner_b         = tri_hit ? cb : '0;
    result.corner_c         = tri_hit ? cur : '0;
    result.triangle_valid   = tri_hit;
    result.end_of_primitive = item.is_last;
    result.status           = st;
  end
  assign has_result = tri_hit | item.is_last;

  // state update, cleared after the last index
  always_ff @(posedge clk) begin
    if (rst) begin
      first_index      <= '0;
      older_index      <= '0;
      newer_index      <= '0;
      index_count      <= '0;
      list_phase       <= PHASE_FIRST;
      range_error_seen <= 1'b0;
    end else if (advance) begin
      if (item.is_last) begin
        first_index      <= '0;
        older_index      <= '0;
        newer_index      <= '0;
        index_count      <= '0;
        list_phase       <= PHASE_FIRST;
        range_error_seen <= 1'b0;
      end else begin
        first_index      <= first_index_next;
        older_index      <= older_index_next;
        newer_index      <= newer_index_next;
        index_count      <= index_count_next;
        list_phase       <= list_phase_next;
        range_error_seen <= range_error_seen_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/tia_out_reg.sv
// ----------------------------------------------------------------------------
// tia_out_reg
// Result register holding one finished transaction for the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tia_out_reg
  import tia_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  input  wire logic    take,
  output logic         full,
  output result_t      data
);

  // valid flag: set on load, cleared when taken without a refill
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

>>> hdl/triangle_index_assembler.sv
// ----------------------------------------------------------------------------
// triangle_index_assembler
// Assembles list, strip and fan index streams into triangles with status.
// ----------------------------------------------------------------------------
// Path: an accepted index is held in the input register, then its result, if any,
//   is loaded into the result register.
// Throughput: one index per cycle; the input register advances whenever the
//   result register is empty or being drained in the same cycle.
// Reset: rst clears the input and result valid flags, the primitive state and
//   the configuration (list mode, index buffer used, vertex count zero).
`timescale 1ns / 1ps
`default_nettype none

module triangle_index_assembler
  import tia_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_addr,
  input  wire logic [CfgW-1:0]    cfg_wdata,
  // index input
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [31:0]        s_axis_tdata,  // [31:0] index_value
  input  wire logic               s_axis_tlast,  // is_last
  // triangle output
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [95:0]             m_axis_tdata,  // [31:0] corner_a, [63:32] corner_b,
                                                 // [95:64] corner_c
  output logic [3:0]              m_axis_tuser,  // [0] triangle_valid, [3:1] status
  output logic                    m_axis_tlast   // end_of_primitive
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_full;
  logic    advance;
  logic    out_full;
  logic    out_take;
  logic    has_result;
  result_t next_result;
  result_t out_data;

  tia_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake between the stages
  assign out_take      = out_full & m_axis_tready;
  assign advance       = in_full & (~out_full | m_axis_tready);
  assign s_axis_tready = ~in_full | advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.index_value <= s_axis_tdata;
      in_item.is_last     <= s_axis_tlast;
    end
  end

  tia_assemble u_asm (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (in_item),
    .advance    (advance),
    .result     (next_result),
    .has_result (has_result)
  );

  tia_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance & has_result),
    .load_data (next_result),
    .take      (out_take),
    .full      (out_full),
    .data      (out_data)
  );

  // output packing
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {out_data.corner_c, out_data.corner_b, out_data.corner_a};
  assign m_axis_tuser  = {out_data.status, out_data.triangle_valid};
  assign m_axis_tlast  = out_data.end_of_primitive;

endmodule

`default_nettype wire

>>> tb/sv/tb_triangle_index_assembler.sv
// ----------------------------------------------------------------------------
// tb_triangle_index_assembler
// Self-checking bench for the triangle index assembler: drives index streams
// in list, strip, fan and unsupported modes, predicts every triangle and the
// end-of-primitive status, and checks each output transaction in order while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_index_assembler;
  import tia_pkg::*;

  localparam int unsigned         CYCLE_LIMIT = 200000;
  localparam int unsigned         HOLD_CYCLES = 300;
  localparam logic [CfgIdxW-1:0]  CFG_UNUSED  = 2'd3;
  localparam logic [IdxW-1:0]     ALL_ONES    = '1;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata = '0;
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [95:0]        m_axis_tdata;
  logic [3:0]         m_axis_tuser;
  logic               m_axis_tlast;

  // stimulus and expectation stores
  item_t   index_queue[$];
  result_t expected_triangles[$];

  // predictor copy of the registers and the primitive state
  logic [ModeW-1:0]  cfg_mode = MODE_LIST;
  logic              cfg_has_index = 1'b1;
  logic [IdxW-1:0]   cfg_vcount = '0;
  logic [IdxW-1:0]   first_idx = '0;
  logic [IdxW-1:0]   older_idx = '0;
  logic [IdxW-1:0]   newer_idx = '0;
  logic [IdxW-1:0]   idx_count = '0;
  logic [PhaseW-1:0] list_phase = PHASE_FIRST;
  logic              range_seen = 1'b0;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        in_fire = 1'b0;
  logic        hold_trigger = 1'b0;
  logic        hold_started = 1'b0;
  int unsigned hold_left = 0;

  triangle_index_assembler DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] index_value
    .s_axis_tlast  (s_axis_tlast),   // is_last
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] corner_a, [63:32] corner_b, [95:64] corner_c
    .m_axis_tuser  (m_axis_tuser),   // [0] triangle_valid, [3:1] status
    .m_axis_tlast  (m_axis_tlast)    // end_of_primitive
  );

  always #10 clk = ~clk;

  // take one index, advance the primitive state, queue the triangle / status
  task automatic assemble_index(input logic [IdxW-1:0] idx_in, input logic last);
    logic [IdxW-1:0] cur;
    logic            tri_ok;
    result_t         res;
    cur    = cfg_has_index ? idx_in : idx_count;
    tri_ok = 1'b0;
    res    = '0;
    if (cur >= cfg_vcount) range_seen = 1'b1;
    case (cfg_mode)
      MODE_LIST: begin
        if (list_phase == PHASE_THIRD) begin
          res.corner_a = older_idx;
          res.corner_b = newer_idx;
          res.corner_c = cur;
          tri_ok = 1'b1;
        end
      end
      MODE_STRIP: begin
        if (idx_count >= 2) begin
          // odd triangles swap their first two corners
          res.corner_a = idx_count[0] ? newer_idx : older_idx;
          res.corner_b = idx_count[0] ? older_idx : newer_idx;
          res.corner_c = cur;
          tri_ok = 1'b1;
        end
      end
      MODE_FAN: begin
        if (idx_count >= 2) begin
          res.corner_a = first_idx;
          res.corner_b = newer_idx;
          res.corner_c = cur;
          tri_ok = 1'b1;
        end
      end
      default: ;
    endcase
    if (idx_count == 0) first_idx = cur;
    if (cfg_mode == MODE_LIST) begin
      if (list_phase == PHASE_FIRST) older_idx = cur;
      else if (list_phase == PHASE_SECOND) newer_idx = cur;
    end else begin
      older_idx = newer_idx;
      newer_idx = cur;
    end
    list_phase = (list_phase >= PHASE_THIRD) ? PHASE_FIRST : list_phase + 1'b1;
    if (idx_count != ALL_ONES) idx_count = idx_count + 1;
    if (tri_ok || last) begin
      if (last) begin
        // range error wins, then the per-mode check (list count, unsupported mode, too few)
        if (range_seen) res.status = ST_RANGE;
        else if (cfg_mode == MODE_LIST) begin
          if (list_phase != PHASE_FIRST) res.status = ST_LISTCOUNT;
        end else if (cfg_mode != MODE_STRIP && cfg_mode != MODE_FAN) res.status = ST_MODE;
        else if (idx_count < 3) res.status = ST_FEW;
      end
      res.triangle_valid   = tri_ok;
      res.end_of_primitive = last;
      expected_triangles.insert(expected_triangles.size(), res);
    end
    if (last) begin
      first_idx  = '0;
      older_idx  = '0;
      newer_idx  = '0;
      idx_count  = '0;
      list_phase = PHASE_FIRST;
      range_seen = 1'b0;
    end
  endtask

  // input side: hold an offered item until taken, idle at random otherwise
  always @(negedge clk) begin : index_driver
    item_t nxt;
    if (!rst && (!s_axis_tvalid || in_fire)) begin
      if (index_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = index_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.index_value;
        s_axis_tlast  <= nxt.is_last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: random stalls plus one long hold-off
  always @(negedge clk) begin
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_trigger && !hold_started) begin
      hold_started <= 1'b1;
      hold_left    <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // predict on accepted indexes, check accepted results
  always @(posedge clk) begin : triangle_monitor
    result_t got;
    result_t exp;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) assemble_index(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.corner_a         = m_axis_tdata[31:0];
        got.corner_b         = m_axis_tdata[63:32];
        got.corner_c         = m_axis_tdata[95:64];
        got.triangle_valid   = m_axis_tuser[0];
        got.status           = m_axis_tuser[3:1];
        got.end_of_primitive = m_axis_tlast;
        if (expected_triangles.size() == 0) begin
          $error("unexpected output transaction: tdata %h tuser %h tlast %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          error_count++;
        end else begin
          exp = expected_triangles.pop_front();
          if (got.corner_a !== exp.corner_a) begin
            $error("corner_a: expected %0h, got %0h", exp.corner_a, got.corner_a);
            error_count++;
          end
          if (got.corner_b !== exp.corner_b) begin
            $error("corner_b: expected %0h, got %0h", exp.corner_b, got.corner_b);
            error_count++;
          end
          if (got.corner_c !== exp.corner_c) begin
            $error("corner_c: expected %0h, got %0h", exp.corner_c, got.corner_c);
            error_count++;
          end
          if (got.triangle_valid !== exp.triangle_valid) begin
            $error("triangle_valid: expected %0d, got %0d",
                   exp.triangle_valid, got.triangle_valid);
            error_count++;
          end
          if (got.end_of_primitive !== exp.end_of_primitive) begin
            $error("end_of_primitive: expected %0d, got %0d",
                   exp.end_of_primitive, got.end_of_primitive);
            error_count++;
          end
          if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_index(input logic [IdxW-1:0] value, input logic last);
    item_t it;
    it.index_value = value;
    it.is_last     = last;
    index_queue.insert(index_queue.size(), it);
  endtask

  // mostly in range, sometimes at or past the vertex count
  function automatic logic [IdxW-1:0] pick_index();
    case ($urandom_range(39))
      0:       return ALL_ONES;
      1:       return $urandom();
      2:       return cfg_vcount;
      default: return (cfg_vcount == 0) ? $urandom() : $urandom() % cfg_vcount;
    endcase
  endfunction

  // wait until every index is taken, every result is in, and the pipe is empty
  task automatic drain();
    while (index_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_triangles.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] addr, input logic [CfgW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_MODE:      cfg_mode      = data[ModeW-1:0];
      CFG_HAS_INDEX: cfg_has_index = data[0];
      CFG_VCOUNT:    cfg_vcount    = data;
      default: ;
    endcase
  endtask

  // all registers in one go, upper write bits random where unused
  task automatic apply_config(input logic [ModeW-1:0] mode, input logic has_index,
                              input logic [IdxW-1:0] vcount);
    logic [CfgW-1:0] data;
    drain();
    data = $urandom();
    data[ModeW-1:0] = mode;
    write_reg(CFG_MODE, data);
    data = $urandom();
    data[0] = has_index;
    write_reg(CFG_HAS_INDEX, data);
    write_reg(CFG_VCOUNT, vcount);
    write_reg(CFG_UNUSED, $urandom());
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned      made;
    int unsigned      len;
    int unsigned      sel;
    logic [ModeW-1:0] mode;
    logic [IdxW-1:0]  vcount;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset defaults, vertex count zero makes everything out of range
    push_index(32'd7, 1'b1);

    // list: good triangle, all-ones index, short count
    apply_config(MODE_LIST, 1'b1, ALL_ONES);
    push_index(32'd0, 1'b0);
    push_index(32'hFFFF_FFFE, 1'b0);
    push_index(32'h1234_5678, 1'b1);
    push_index(ALL_ONES, 1'b1);
    push_index(32'd1, 1'b0);
    push_index(32'd2, 1'b1);

    // strip with corner swap, then too few indices
    apply_config(MODE_STRIP, 1'b1, ALL_ONES);
    push_index(32'd1, 1'b0);
    push_index(32'd2, 1'b0);
    push_index(32'd3, 1'b0);
    push_index(32'd4, 1'b0);
    push_index(32'd5, 1'b1);
    push_index(32'd9, 1'b0);
    push_index(32'd8, 1'b1);

    // fan shares the first index
    apply_config(MODE_FAN, 1'b1, ALL_ONES);
    push_index(32'd10, 1'b0);
    push_index(32'd11, 1'b0);
    push_index(32'd12, 1'b0);
    push_index(32'd13, 1'b1);

    // unsupported mode
    apply_config(MODE_OTHER, 1'b1, ALL_ONES);
    push_index(32'd1, 1'b0);
    push_index(32'd2, 1'b0);
    push_index(32'd3, 1'b1);

    // sequential indices, last one hits the vertex count
    apply_config(MODE_STRIP, 1'b0, 32'd3);
    push_index($urandom(), 1'b0);
    push_index($urandom(), 1'b0);
    push_index($urandom(), 1'b0);
    push_index($urandom(), 1'b1);

    // random groups: receiver idles, then sender idles, then no idling
    for (int grp = 0; grp < 15; grp++) begin
      sel = $urandom_range(9);
      mode = (sel < 3) ? MODE_LIST : (sel < 6) ? MODE_STRIP : (sel < 9) ? MODE_FAN : MODE_OTHER;
      case ($urandom_range(7))
        0:       vcount = '0;
        1:       vcount = ALL_ONES;
        2:       vcount = 32'd1;
        3:       vcount = $urandom();
        default: vcount = $urandom_range(64, 3);
      endcase
      apply_config(mode, $urandom_range(3) != 0, vcount);
      if (grp < 5) begin
        send_idle_pct = 6;
        recv_idle_pct = 68;
      end else if (grp < 10) begin
        send_idle_pct = 68;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (grp == 10) hold_trigger = 1'b1;
      // the group may end mid-primitive; its state carries into the next setting
      made = 0;
      while (made < 50) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
        for (int k = 0; k < len && made < 50; k++) begin
          push_index(pick_index(), k == len - 1);
          made++;
        end
      end
    end

    drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
